// File: rtl/qpm_pkg.sv
`default_nettype none

package qpm_pkg;

  // Sizes
  localparam int MAX_POINTS    = 1024;
  localparam int IDX_BITS      = $clog2(MAX_POINTS);
  localparam int NP_BITS       = IDX_BITS + 1;
  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 15;
  localparam int PHASE_BITS    = 32;

  // Centred index d = 2*index - num_points and its square
  localparam int DW  = NP_BITS + 1;
  localparam int SQW = 2 * NP_BITS;

  // CORDIC gain 0.60725293500888 in Q0.31, applied before the rotation
  localparam int GAIN_BITS = 31;
  localparam logic [GAIN_BITS-1:0] GAIN_Q31 = 31'd1304065748;
  localparam int PRE_SHIFT = 16;
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

  // Datapath width of the rotator, with headroom for CORDIC growth
  localparam int XW = SAMPLE_BITS + GUARD_BITS + 3;

  // Pipeline depth: three front stages, the CORDIC stages, one output stage
  localparam int LATENCY = CORDIC_STAGES + 4;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_POINTS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHIRP_COEFF = 2'd1;

  // atan(2^-k) in units of 2^-32 turn
  localparam logic [PHASE_BITS-1:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // One item inside the rotator: vector and residual angle
  typedef struct packed {
    logic signed [XW-1:0]         x;
    logic signed [XW-1:0]         y;
    logic signed [PHASE_BITS-1:0] r;
  } qpm_rot_t;

endpackage

`default_nettype wire

// File: rtl/qpm_front.sv
`default_nettype none

module qpm_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic signed [qpm_pkg::SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [qpm_pkg::SAMPLE_BITS-1:0] sample_im_i,
  input  logic        [qpm_pkg::IDX_BITS-1:0]    sample_index_i,
  input  logic        [qpm_pkg::NP_BITS-1:0]     num_points_i,
  input  logic        [qpm_pkg::PHASE_BITS-1:0]  chirp_coeff_i,
  output logic                                   rot_valid_o,
  output qpm_pkg::qpm_rot_t                      rot_o
);
  import qpm_pkg::*;

  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;
  localparam logic [PHASE_BITS-1:0] HALF_QUAD = PHASE_BITS'(1) << (PHASE_BITS - 3);

  // Stage A: centred index squared, gain pre-scale products
  logic signed [DW-1:0]        d;
  logic signed [2*DW-1:0]      d_sq;
  logic                        v_a_q;
  logic        [SQW-1:0]       sq_a_q;
  logic signed [PROD_BITS-1:0] pre_re_a_q, pre_im_a_q;

  assign d    = $signed({1'b0, sample_index_i, 1'b0}) - $signed({1'b0, num_points_i});
  assign d_sq = d * d;

  // Stage B: phase word, pre-scaled vector
  logic [PHASE_BITS+1:0]  ph_prod;
  logic                   v_b_q;
  logic [PHASE_BITS-1:0]  ph_b_q;
  logic signed [XW-1:0]   x_b_q, y_b_q;

  assign ph_prod = (PHASE_BITS+2)'(chirp_coeff_i) * (PHASE_BITS+2)'(sq_a_q);

  // Stage C: whole-quadrant turn and residual angle
  logic [PHASE_BITS-1:0] ph_adj;
  logic [1:0]            quad;
  logic                  v_c_q;
  qpm_rot_t              rot_c_d, rot_c_q;

  assign ph_adj = ph_b_q + HALF_QUAD;
  assign quad   = ph_adj[PHASE_BITS-1 -: 2];

  always_comb begin
    rot_c_d.r = $signed(ph_b_q - {quad, {(PHASE_BITS-2){1'b0}}});
    case (quad)
      QUAD_0: begin
        rot_c_d.x = x_b_q;
        rot_c_d.y = y_b_q;
      end
      QUAD_90: begin
        rot_c_d.x = -y_b_q;
        rot_c_d.y = x_b_q;
      end
      QUAD_180: begin
        rot_c_d.x = -x_b_q;
        rot_c_d.y = -y_b_q;
      end
      QUAD_270: begin
        rot_c_d.x = y_b_q;
        rot_c_d.y = -x_b_q;
      end
      default: begin
        rot_c_d.x = x_b_q;
        rot_c_d.y = y_b_q;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else begin
      v_a_q <= in_valid_i;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    sq_a_q     <= d_sq[SQW-1:0];
    pre_re_a_q <= sample_re_i * $signed({1'b0, GAIN_Q31});
    pre_im_a_q <= sample_im_i * $signed({1'b0, GAIN_Q31});
    ph_b_q     <= ph_prod[PHASE_BITS+1:2];
    x_b_q      <= XW'($signed(pre_re_a_q[PROD_BITS-1:PRE_SHIFT]));
    y_b_q      <= XW'($signed(pre_im_a_q[PROD_BITS-1:PRE_SHIFT]));
    rot_c_q    <= rot_c_d;
  end

  assign rot_valid_o = v_c_q;
  assign rot_o       = rot_c_q;

endmodule

`default_nettype wire

// File: rtl/qpm_cordic.sv
`default_nettype none

module qpm_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rot_valid_i,
  input  qpm_pkg::qpm_rot_t rot_i,
  output logic              rot_valid_o,
  output qpm_pkg::qpm_rot_t rot_o
);
  import qpm_pkg::*;

  qpm_rot_t stage_in [CORDIC_STAGES+1];
  logic     valid_in [CORDIC_STAGES+1];

  assign stage_in[0] = rot_i;
  assign valid_in[0] = rot_valid_i;

  // One micro-rotation per pipeline stage
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    qpm_rot_t             st_d, st_q;
    logic                 v_q;
    logic signed [XW-1:0] xs, ys;

    assign xs = stage_in[k].x >>> k;
    assign ys = stage_in[k].y >>> k;

    always_comb begin
      if (!stage_in[k].r[PHASE_BITS-1]) begin
        st_d.x = stage_in[k].x - ys;
        st_d.y = stage_in[k].y + xs;
        st_d.r = stage_in[k].r - $signed(ATAN_TURNS[k]);
      end else begin
        st_d.x = stage_in[k].x + ys;
        st_d.y = stage_in[k].y - xs;
        st_d.r = stage_in[k].r + $signed(ATAN_TURNS[k]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= valid_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q <= st_d;
    end

    assign stage_in[k+1] = st_q;
    assign valid_in[k+1] = v_q;
  end

  assign rot_valid_o = valid_in[CORDIC_STAGES];
  assign rot_o       = stage_in[CORDIC_STAGES];

endmodule

`default_nettype wire

// File: rtl/qpm_finish.sv
`default_nettype none

module qpm_finish (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   rot_valid_i,
  input  qpm_pkg::qpm_rot_t                      rot_i,
  output logic                                   out_valid_o,
  output logic signed [qpm_pkg::SAMPLE_BITS-1:0] out_re_o,
  output logic signed [qpm_pkg::SAMPLE_BITS-1:0] out_im_o
);
  import qpm_pkg::*;

  localparam logic signed [XW:0] ROUND_HALF = (XW+1)'(1) << (GUARD_BITS - 1);
  localparam logic signed [XW:0] SAT_HI     = (XW+1)'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [XW:0] SAT_LO     = ~SAT_HI;

  // Round half up, drop guard bits, clamp to the sample range
  function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [XW-1:0] v);
    logic signed [XW:0] rnd;
    logic signed [XW:0] sh;
    rnd = (XW+1)'(v) + ROUND_HALF;
    sh  = rnd >>> GUARD_BITS;
    if (sh > SAT_HI) begin
      round_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sh < SAT_LO) begin
      round_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      round_sat = sh[SAMPLE_BITS-1:0];
    end
  endfunction

  logic                   v_q;
  logic [SAMPLE_BITS-1:0] re_q, im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= rot_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= round_sat(rot_i.x);
    im_q <= round_sat(rot_i.y);
  end

  // The residual angle is spent once the vector leaves the rotator
  logic unused_r;
  assign unused_r = ^rot_i.r;

  assign out_valid_o = v_q;
  assign out_re_o    = $signed(re_q);
  assign out_im_o    = $signed(im_q);

endmodule

`default_nettype wire

// File: rtl/quadratic_phase_mask.sv
`default_nettype none

// Quadratic phase mask: turns each complex sample by a thin-lens phase
// chirp_coeff * (index - num_points/2)^2, in units of 2^-32 turn, using a pipelined CORDIC.
//
// Input: an item (sample_re_i, sample_im_i, sample_index_i) is taken at a
// rising edge with start high and busy low. busy stays low, so one item can
// enter every cycle: throughput is one item per clock.
// Output: each result appears on out_re_o / out_im_o with out_valid_o high
// after three front stages (square, phase multiply and quadrant turn), one stage
// per CORDIC micro-rotation and one rounding stage. Results leave in input
// order. The receiver cannot stall; nothing waits for it.
// Config: num_points (index 0) and chirp_coeff (index 1) are written over
// cfg_valid_i/cfg_ready_o; cfg_ready_o is always high. Write them only while
// no items are in flight. Other indexes are ignored.
// Reset: clears every valid bit of the pipeline at once; num_points returns
// to 1024 and chirp_coeff to zero. No items are lost or made up by reset
// beyond those in flight, which are dropped.

module quadratic_phase_mask (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [qpm_pkg::SAMPLE_BITS-1:0]   sample_re_i,
  input  logic signed [qpm_pkg::SAMPLE_BITS-1:0]   sample_im_i,
  input  logic        [qpm_pkg::IDX_BITS-1:0]      sample_index_i,
  output logic                                     out_valid_o,
  output logic signed [qpm_pkg::SAMPLE_BITS-1:0]   out_re_o,
  output logic signed [qpm_pkg::SAMPLE_BITS-1:0]   out_im_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic        [qpm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic        [qpm_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import qpm_pkg::*;

  // Configuration registers
  logic [NP_BITS-1:0]    num_points_q;
  logic [PHASE_BITS-1:0] chirp_coeff_q;
  logic                  cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q  <= NP_BITS'(MAX_POINTS);
      chirp_coeff_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_NUM_POINTS:  num_points_q  <= cfg_data_i[NP_BITS-1:0];
        CFG_CHIRP_COEFF: chirp_coeff_q <= cfg_data_i[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never holds off an item
  logic in_accept;
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  logic     front_valid, cordic_valid;
  qpm_rot_t front_rot, cordic_rot;

  qpm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_accept),
    .sample_re_i    (sample_re_i),
    .sample_im_i    (sample_im_i),
    .sample_index_i (sample_index_i),
    .num_points_i   (num_points_q),
    .chirp_coeff_i  (chirp_coeff_q),
    .rot_valid_o    (front_valid),
    .rot_o          (front_rot)
  );

  qpm_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rot_valid_i (front_valid),
    .rot_i       (front_rot),
    .rot_valid_o (cordic_valid),
    .rot_o       (cordic_rot)
  );

  qpm_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rot_valid_i (cordic_valid),
    .rot_i       (cordic_rot),
    .out_valid_o (out_valid_o),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o)
  );

`ifndef SYNTHESIS
  // Every result traces back to an accepted item
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(in_accept, LATENCY))
    else $error("result without a matching item");

  // A write to an unknown index leaves both registers alone
  a_bad_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && cfg_index_i != CFG_NUM_POINTS && cfg_index_i != CFG_CHIRP_COEFF)
    |=> ($stable(num_points_q) && $stable(chirp_coeff_q)))
    else $error("config write to unknown index changed a register");

  // A coefficient write lands in the register
  a_chirp_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && cfg_index_i == CFG_CHIRP_COEFF)
    |=> (chirp_coeff_q == $past(cfg_data_i[PHASE_BITS-1:0])))
    else $error("chirp coefficient write lost");
`endif

endmodule

`default_nettype wire

// File: tb/sv/qpm_chirp_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the phase mask,
// predicts every rotated sample and compares it with what comes out.
module qpm_chirp_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic                                     busy_i,
  input  logic signed [qpm_pkg::SAMPLE_BITS-1:0]   sample_re_i,
  input  logic signed [qpm_pkg::SAMPLE_BITS-1:0]   sample_im_i,
  input  logic        [qpm_pkg::IDX_BITS-1:0]      sample_index_i,
  input  logic                                     out_valid_i,
  input  logic signed [qpm_pkg::SAMPLE_BITS-1:0]   out_re_i,
  input  logic signed [qpm_pkg::SAMPLE_BITS-1:0]   out_im_i,
  input  logic                                     cfg_valid_i,
  input  logic                                     cfg_ready_i,
  input  logic        [qpm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic        [qpm_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output int                                       mismatch_count_o,
  output int                                       in_flight_o
);

  import qpm_pkg::*;

  // CORDIC gain in Q0.31 and atan(2^-k) in 2^-32 turn
  localparam longint ROT_GAIN = 64'd1304065748;
  localparam longint ARCTAN_TURNS [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  // Whole-quadrant turns
  localparam logic [1:0] TURN_90  = 2'd1;
  localparam logic [1:0] TURN_180 = 2'd2;
  localparam logic [1:0] TURN_270 = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } rotated_t;

  rotated_t             rotated_q [$];
  logic [NP_BITS-1:0]   points_cfg;
  logic [31:0]          coeff_cfg;
  int                   fails;

  // Round off the guard bits and clamp to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(longint v);
    longint hi;
    longint lo;
    longint t;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    t  = (v + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[SAMPLE_BITS-1:0];
  endfunction

  // Expected sample after the quadratic phase turn
  function automatic rotated_t chirp_rotate(logic signed [SAMPLE_BITS-1:0] re,
                                            logic signed [SAMPLE_BITS-1:0] im,
                                            logic [IDX_BITS-1:0]           idx,
                                            logic [NP_BITS-1:0]            npts,
                                            logic [31:0]                   coeff);
    longint            idx_l;
    longint            np_l;
    longint            d;
    longint unsigned   sq;
    longint unsigned   prod;
    logic [31:0]       phase;
    logic [31:0]       biased;
    logic [31:0]       resid;
    logic [1:0]        quad;
    longint            rv;
    longint            xv;
    longint            yv;
    longint            xs;
    longint            ys;
    longint            tmp;
    int                k;
    rotated_t          res;
    idx_l  = idx;
    np_l   = npts;
    d      = 2 * idx_l - np_l;
    sq     = longint'(d * d);
    prod   = coeff * sq;
    phase  = prod[33:2];
    biased = phase + 32'h2000_0000;
    quad   = biased[31:30];
    resid  = phase - {quad, 30'd0};
    rv     = longint'($signed(resid));
    xv     = (longint'(re) * ROT_GAIN) >>> PRE_SHIFT;
    yv     = (longint'(im) * ROT_GAIN) >>> PRE_SHIFT;
    case (quad)
      TURN_90: begin
        tmp = xv; xv = -yv; yv = tmp;
      end
      TURN_180: begin
        xv = -xv; yv = -yv;
      end
      TURN_270: begin
        tmp = xv; xv = yv; yv = -tmp;
      end
      default: ;
    endcase
    for (k = 0; k < CORDIC_STAGES && k < 32; k++) begin
      xs = xv >>> k;
      ys = yv >>> k;
      if (rv >= 0) begin
        xv -= ys; yv += xs; rv -= ARCTAN_TURNS[k];
      end else begin
        xv += ys; yv -= xs; rv += ARCTAN_TURNS[k];
      end
    end
    res.re = round_sat(xv);
    res.im = round_sat(yv);
    return res;
  endfunction

  // Predict on accept, compare on each strobe, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    rotated_t want;
    if (!rst_ni) begin
      points_cfg = NP_BITS'(MAX_POINTS);
      coeff_cfg  = '0;
      fails      = 0;
      rotated_q.delete();
      mismatch_count_o <= 0;
      in_flight_o      <= 0;
    end else begin
      if (out_valid_i) begin
        if (rotated_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual re %0d im %0d",
                   $time, out_re_i, out_im_i);
          fails++;
        end else begin
          want = rotated_q.pop_front();
          if (out_re_i !== want.re) begin
            $display("%0t out_re mismatch: expected %0d, actual %0d",
                     $time, want.re, out_re_i);
            fails++;
          end
          if (out_im_i !== want.im) begin
            $display("%0t out_im mismatch: expected %0d, actual %0d",
                     $time, want.im, out_im_i);
            fails++;
          end
        end
      end
      // item sees the registers as they were before this edge
      if (start_i && !busy_i)
        rotated_q.push_back(chirp_rotate(sample_re_i, sample_im_i, sample_index_i,
                                         points_cfg, coeff_cfg));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NUM_POINTS:  points_cfg = cfg_data_i[NP_BITS-1:0];
          CFG_CHIRP_COEFF: coeff_cfg  = cfg_data_i[31:0];
          default: ;
        endcase
      end
      mismatch_count_o <= fails;
      in_flight_o      <= rotated_q.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import qpm_pkg::*;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            start          = 1'b0;
  logic                            busy;
  logic signed [SAMPLE_BITS-1:0]   sample_re_i    = '0;
  logic signed [SAMPLE_BITS-1:0]   sample_im_i    = '0;
  logic        [IDX_BITS-1:0]      sample_index_i = '0;
  logic                            out_valid_o;
  logic signed [SAMPLE_BITS-1:0]   out_re_o;
  logic signed [SAMPLE_BITS-1:0]   out_im_o;
  logic                            cfg_valid_i    = 1'b0;
  logic                            cfg_ready_o;
  logic        [CFG_IDX_BITS-1:0]  cfg_index_i    = '0;
  logic        [CFG_DATA_BITS-1:0] cfg_data_i     = '0;
  int                              mismatches;
  int                              in_flight;

  always #1 clk_i = ~clk_i;

  quadratic_phase_mask u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_re_i    (sample_re_i),
    .sample_im_i    (sample_im_i),
    .sample_index_i (sample_index_i),
    .out_valid_o    (out_valid_o),
    .out_re_o       (out_re_o),
    .out_im_o       (out_im_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  qpm_chirp_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .sample_re_i      (sample_re_i),
    .sample_im_i      (sample_im_i),
    .sample_index_i   (sample_index_i),
    .out_valid_i      (out_valid_o),
    .out_re_i         (out_re_o),
    .out_im_i         (out_im_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .in_flight_o      (in_flight)
  );

  // Offer one item and hold it until taken; start stays high afterwards
  task automatic push_sample(logic signed [SAMPLE_BITS-1:0] re,
                             logic signed [SAMPLE_BITS-1:0] im,
                             logic [IDX_BITS-1:0]           idx);
    start          <= 1'b1;
    sample_re_i    <= re;
    sample_im_i    <= im;
    sample_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Random gap, pct percent chance per cycle
  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < pct) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every result is out
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Point count in the low bits, noise above
  task automatic set_points(logic [NP_BITS-1:0] npts);
    logic [CFG_DATA_BITS-1:0] word;
    word = $urandom;
    word[NP_BITS-1:0] = npts;
    write_reg(CFG_NUM_POINTS, word);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic [31:0] rnd;
    int          sel;
    rnd = $urandom;
    sel = $urandom_range(15);
    if (sel == 0) return S_MAX;
    if (sel == 1) return S_MIN;
    if (sel == 2) return '0;
    return rnd[SAMPLE_BITS-1:0];
  endfunction

  task automatic run_random(int count, int pct);
    logic [31:0] rnd;
    int          i;
    for (i = 0; i < count; i++) begin
      sender_gap(pct);
      rnd = $urandom;
      push_sample(pick_sample(), pick_sample(), rnd[IDX_BITS-1:0]);
    end
  endtask

  initial begin : stimulus
    logic [31:0]        quad_coeff [4];
    logic [NP_BITS-1:0] npts;
    logic [31:0]        coeff;
    int                 pct;
    int                 ph;
    int                 i;
    quad_coeff = '{32'h4000_0000, 32'h8000_0000, 32'hC000_0000, 32'hE000_0000};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting, zero phase; writes to unused indexes must do nothing
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    push_sample(S_MAX, S_MAX, 10'd0);
    push_sample(S_MIN, S_MIN, 10'd1023);
    push_sample(S_MIN, S_MAX, 10'd512);
    push_sample(S_MAX, S_MIN, 10'd511);

    // Index 513 with 1024 points gives phase = coeff: hit each quadrant
    // and the wrap where the quadrant rounds back to zero
    for (i = 0; i < 4; i++) begin
      wait_drained();
      write_reg(CFG_CHIRP_COEFF, quad_coeff[i]);
      push_sample(S_MAX, S_MIN, 10'd513);
      push_sample(S_MIN, 16'sd12345, 10'd0);
    end

    // Odd point count: centre is a half-integer
    wait_drained();
    set_points(11'd1023);
    write_reg(CFG_CHIRP_COEFF, $urandom);
    push_sample(pick_sample(), pick_sample(), 10'd0);
    push_sample(pick_sample(), pick_sample(), 10'd511);
    push_sample(pick_sample(), pick_sample(), 10'd512);
    push_sample(pick_sample(), pick_sample(), 10'd1023);

    // Point count zero and above range
    wait_drained();
    set_points(11'd0);
    push_sample(S_MAX, S_MAX, 10'd0);
    push_sample(S_MIN, S_MAX, 10'd1023);
    wait_drained();
    set_points(11'd2047);
    push_sample(S_MAX, S_MIN, 10'd0);
    push_sample(S_MIN, S_MIN, 10'd1023);

    // Random phases: sender idles 25%, then 49%, then never
    for (ph = 0; ph < 12; ph++) begin
      wait_drained();
      case (ph)
        0: begin npts = 11'd1024; coeff = 32'hFFFF_FFFF; end
        1: begin npts = 11'd1;    coeff = 32'd1; end
        2: begin npts = 11'd2047; coeff = $urandom; end
        3: begin npts = 11'd1023; coeff = $urandom_range(4095); end
        4: begin npts = 11'd0;    coeff = 32'h8000_0001; end
        5: begin npts = 11'd2;    coeff = $urandom; end
        default: begin
          npts  = ($urandom_range(3) == 0) ? 11'($urandom_range(2047))
                                           : 11'($urandom_range(1024, 1));
          coeff = $urandom;
        end
      endcase
      set_points(npts);
      write_reg(CFG_CHIRP_COEFF, coeff);
      pct = (ph < 4) ? 25 : (ph < 8) ? 49 : 0;
      run_random(69, pct);
      // hold off once until the pipeline is empty
      if (ph == 6) wait_drained();
      run_random(69, pct);
    end

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #400000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
